[sv/nzr_pkg.sv]
package nzr_pkg;

    localparam logic [2:0] CH_TWO  = 3'd2;
    localparam logic [2:0] CH_FOUR = 3'd4;
    localparam logic [2:0] CH_MAX  = 3'd7;

    typedef enum logic [1:0] {
        MODE_RECON,
        MODE_COPY,
        MODE_PASS
    } mode_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] a;
        logic        recon;
    } side_t;

endpackage

[sv/normal_z_reconstruct_rgba.sv]
// Normal-map texel expander: one RGBA texel out for every texel in.
// Input request: s_valid/s_ready with s_comp_x, s_comp_y, s_comp_z, s_comp_a.
// Result request: m_valid/m_ready with m_out_x, m_out_y, m_out_z, m_out_a.
// cfg_wr_en/cfg_wr_data set the source channel count: 2 rebuilds Z from X and
// Y and sets alpha to full scale, 3 (and 0, 1) copies Z and sets full alpha,
// 4 to 7 pass the texel through. Write it only while the pipeline is empty.
// Registered steps in order: offset, square, radicand, one square-root bit per
// stage, then pack and output register.
// One texel per cycle when not stalled; the square root is fully pipelined.
// The whole pipeline advances when the output register is empty or taken,
// so s_ready follows m_ready whenever a result is waiting.
// When the receiver stalls, every stage holds, valid bits included.
// Reset (aresetn low, synchronous) empties the pipeline and sets the channel
// count to 2.
module normal_z_reconstruct_rgba
    import nzr_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_comp_x,
    input  logic [15:0] s_comp_y,
    input  logic [15:0] s_comp_z,
    input  logic [15:0] s_comp_a,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_x,
    output logic [15:0] m_out_y,
    output logic [15:0] m_out_z,
    output logic [15:0] m_out_a
);

    localparam int CB  = COMPONENT_BITS;
    localparam int EW  = (CB > 16) ? CB : 16;
    localparam int RW  = CB + 2;
    localparam int NST = CB + 4;
    localparam logic [CB-1:0]   FS    = {CB{1'b1}};
    localparam logic [2*CB-1:0] FS_SQ = (2*CB)'(FS) * (2*CB)'(FS);
    localparam logic [CB-1:0]   HALF  = CB'((2**CB) / 2);

    logic [2:0] src_ch_reg;
    logic [NST-1:0] v_reg;
    logic adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_ch_reg <= CH_TWO;
        end else if (cfg_wr_en) begin
            src_ch_reg <= cfg_wr_data;
        end
    end

    assign adv     = !v_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_valid};
        end
    end

    // input masking and mode decode
    mode_t mode;
    logic [EW-1:0] ex_x, ex_y, ex_z, ex_a, ex_fs;
    logic [EW-1:0] mx, my, mz, ma;
    logic [CB-1:0] cx, cy;
    logic [CB:0]   twice_x, twice_y;
    logic [CB-1:0] dx_next, dy_next;
    side_t side_next;

    always_comb begin
        unique case (src_ch_reg) inside
            CH_TWO:            mode = MODE_RECON;
            [CH_FOUR:CH_MAX]:  mode = MODE_PASS;
            default:           mode = MODE_COPY;
        endcase
    end

    always_comb begin
        ex_x  = EW'(s_comp_x);
        ex_y  = EW'(s_comp_y);
        ex_z  = EW'(s_comp_z);
        ex_a  = EW'(s_comp_a);
        ex_fs = EW'(FS);
        cx    = ex_x[CB-1:0];
        cy    = ex_y[CB-1:0];
        mx    = EW'(cx);
        my    = EW'(cy);
        mz    = EW'(ex_z[CB-1:0]);
        ma    = EW'(ex_a[CB-1:0]);
        twice_x = {cx, 1'b0};
        twice_y = {cy, 1'b0};
        dx_next = (twice_x >= {1'b0, FS}) ? CB'(twice_x - {1'b0, FS})
                                          : CB'({1'b0, FS} - twice_x);
        dy_next = (twice_y >= {1'b0, FS}) ? CB'(twice_y - {1'b0, FS})
                                          : CB'({1'b0, FS} - twice_y);
        side_next.x     = mx[15:0];
        side_next.y     = my[15:0];
        side_next.z     = mz[15:0];
        side_next.a     = (mode == MODE_PASS) ? ma[15:0] : ex_fs[15:0];
        side_next.recon = (mode == MODE_RECON);
    end

    side_t side_reg [NST-1];
    logic [CB-1:0]   dx_reg, dy_reg;
    logic [2*CB-1:0] sqx_reg, sqy_reg;
    logic [2*CB:0]   sum_sq;

    logic [RW-1:0]   rem_reg  [CB+1];
    logic [CB-1:0]   root_reg [CB+1];
    logic [2*CB-1:0] rad_reg  [CB+1];

    assign sum_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < NST - 1; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            rad_reg[0]  <= (sum_sq >= {1'b0, FS_SQ}) ? '0
                                                     : (2*CB)'({1'b0, FS_SQ} - sum_sq);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar j = 0; j < CB; j++) begin : g_sqrt
        logic [RW:0] rem_sh;
        logic [RW:0] trial;
        logic        take;

        assign rem_sh = {rem_reg[j][CB:0], rad_reg[j][2*CB-1 -: 2]};
        assign trial  = {1'b0, root_reg[j], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j+1]  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
                root_reg[j+1] <= {root_reg[j][CB-2:0], take};
                rad_reg[j+1]  <= {rad_reg[j][2*CB-3:0], 2'b00};
            end
        end
    end

    logic [CB:0]   z_sum;
    logic [CB-1:0] z_pack;
    logic [EW-1:0] z_ext;
    side_t side_last;

    always_comb begin
        side_last = side_reg[NST-2];
        z_sum  = {1'b0, root_reg[CB]} + {1'b0, FS} + (CB+1)'(1);
        z_pack = z_sum[CB:1];
        z_ext  = EW'(z_pack);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_out_x <= side_last.x;
            m_out_y <= side_last.y;
            m_out_z <= side_last.recon ? z_ext[15:0] : side_last.z;
            m_out_a <= side_last.a;
        end
    end

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is taken");

    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NST-2] |-> ({1'b0, rem_reg[CB]} <= {2'b00, root_reg[CB], 1'b0}))
        else $error("square root remainder out of range");

    a_z_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NST-2] && side_last.recon) |-> (z_pack >= HALF))
        else $error("rebuilt Z below zero point");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_reg) && $stable(root_reg[CB]))
        else $error("pipeline moved during stall");

endmodule

[tb/sv/normal_z_reconstruct_rgba_test.sv]
`timescale 1ns / 100ps

module normal_z_reconstruct_rgba_test
    import nzr_pkg::*;
();

    localparam longint unsigned FULL = 65535;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 64;
    localparam int PHASE_TEXELS = 110;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] a;
        bit          flush;
    } texel_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] a;
    } rgba_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_comp_x = 16'h0000;
    logic [15:0] s_comp_y = 16'h0000;
    logic [15:0] s_comp_z = 16'h0000;
    logic [15:0] s_comp_a = 16'h0000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_out_x;
    logic [15:0] m_out_y;
    logic [15:0] m_out_z;
    logic [15:0] m_out_a;

    texel_t      texel_q[$];
    rgba_t       rgba_q[$];
    texel_t      next_texel;
    texel_t      seen_texel;
    rgba_t       want;
    logic [2:0]  chan_count = CH_TWO;
    bit          quiet = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    bit          long_done = 1'b0;
    int          texels_in = 0;
    int          errors = 0;
    int          idle_cycles = 0;

    normal_z_reconstruct_rgba uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_comp_x    (s_comp_x),
        .s_comp_y    (s_comp_y),
        .s_comp_z    (s_comp_z),
        .s_comp_a    (s_comp_a),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_out_a     (m_out_a)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic longint unsigned offset_mag(logic [15:0] c);
        longint unsigned twice;
        twice = 2 * longint'(c);
        return (twice >= FULL) ? twice - FULL : FULL - twice;
    endfunction

    function automatic logic [15:0] rebuilt_z(logic [15:0] cx, logic [15:0] cy);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned sum;
        longint unsigned rad;
        longint unsigned z;
        dx = offset_mag(cx);
        dy = offset_mag(cy);
        sum = dx * dx + dy * dy;
        rad = (sum >= FULL * FULL) ? 0 : FULL * FULL - sum;
        z = (root_floor(rad) + FULL + 1) >> 1;
        if (z > FULL) begin
            z = FULL;
        end
        return z[15:0];
    endfunction

    function automatic mode_t channel_mode(logic [2:0] ch);
        if (ch >= CH_FOUR) begin
            return MODE_PASS;
        end
        if (ch == CH_TWO) begin
            return MODE_RECON;
        end
        return MODE_COPY;
    endfunction

    function automatic rgba_t expand_texel(texel_t t, logic [2:0] ch);
        rgba_t r;
        r.x = t.x;
        r.y = t.y;
        r.z = t.z;
        r.a = FULL[15:0];
        case (channel_mode(ch))
            MODE_RECON: begin
                r.z = rebuilt_z(t.x, t.y);
            end
            MODE_PASS: begin
                r.a = t.a;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(32767 + $urandom_range(0, 1));
            3: return 16'(31268 + $urandom_range(0, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    // pick a partner component that puts the pair on or near the unit circle
    function automatic logic [15:0] rim_partner(logic [15:0] cx);
        longint unsigned d;
        longint unsigned root;
        int c;
        d = offset_mag(cx);
        root = root_floor(FULL * FULL - d * d);
        c = ($urandom_range(0, 1) != 0) ? int'((FULL + root) / 2) : int'((FULL - root) / 2);
        c = c + int'($urandom_range(0, 2)) - 1;
        if (c < 0) begin
            c = 0;
        end
        if (c > int'(FULL)) begin
            c = int'(FULL);
        end
        return 16'(c);
    endfunction

    task automatic push_texel(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] a, bit flush);
        texel_t t;
        t.x = x;
        t.y = y;
        t.z = z;
        t.a = a;
        t.flush = flush;
        texel_q.insert(texel_q.size(), t);
    endtask

    task automatic push_random(bit flush);
        logic [15:0] x;
        logic [15:0] y;
        x = rand_comp();
        y = ($urandom_range(0, 3) == 0) ? rim_partner(x) : rand_comp();
        if ($urandom_range(0, 1) != 0) begin
            push_texel(x, y, 16'($urandom), 16'($urandom), flush);
        end else begin
            push_texel(y, x, 16'($urandom), 16'($urandom), flush);
        end
    endtask

    task automatic wait_drained();
        while (texel_q.size() != 0 || s_valid || rgba_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_channels(logic [2:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        chan_count = v;
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                send_gap <= $urandom_range(0, 4);
            end else if (texel_q.size() != 0 &&
                         !(texel_q[0].flush && (s_valid || rgba_q.size() != 0))) begin
                next_texel = texel_q.pop_front();
                s_valid <= 1'b1;
                s_comp_x <= next_texel.x;
                s_comp_y <= next_texel.y;
                s_comp_z <= next_texel.z;
                s_comp_a <= next_texel.a;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen_texel.x = s_comp_x;
                seen_texel.y = s_comp_y;
                seen_texel.z = s_comp_z;
                seen_texel.a = s_comp_a;
                seen_texel.flush = 1'b0;
                rgba_q.insert(rgba_q.size(), expand_texel(seen_texel, chan_count));
                texels_in++;
            end
            if (m_valid && m_ready) begin
                if (rgba_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h %h %h %h",
                             $time, m_out_x, m_out_y, m_out_z, m_out_a);
                    errors++;
                end else begin
                    want = rgba_q.pop_front();
                    check_field("out_x", want.x, m_out_x);
                    check_field("out_y", want.y, m_out_y);
                    check_field("out_z", want.z, m_out_z);
                    check_field("out_a", want.a, m_out_a);
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!long_done && texels_in >= 300) begin
                m_ready <= 1'b0;
                hold_left <= LONG_HOLD;
                long_done <= 1'b1;
            end else if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                recv_gap <= $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    logic [15:0] corner_xy [12][2] = '{
        '{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h0000, 16'hFFFF},
        '{16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h8000}, '{16'h7FFF, 16'h8000},
        '{16'h0000, 16'h7FFF}, '{16'hFFFF, 16'h8000}, '{16'h8000, 16'h0000},
        '{16'hAAAA, 16'h5555}, '{16'h5555, 16'hAAAA}, '{16'h2581, 16'h8000}
    };
    logic [15:0] fill_pat [4] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
    logic [2:0]  phase_ch [9] = '{3'd3, 3'd4, CH_TWO, 3'd0, CH_MAX, 3'd1, 3'd5, 3'd6, CH_TWO};

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 12; i++) begin
            push_texel(corner_xy[i][0], corner_xy[i][1], fill_pat[i % 4],
                       fill_pat[(i + 1) % 4], 1'b0);
        end
        for (int p = 0; p < 9; p++) begin
            wait_drained();
            write_channels(phase_ch[p]);
            if (p == 8) begin
                quiet <= 1'b1;
            end
            push_texel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
            push_texel(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
            for (int i = 0; i < PHASE_TEXELS; i++) begin
                push_random(p == 2 && i == 50);
            end
        end
        wait_drained();
        repeat (32) @(posedge aclk);
        if (errors == 0 && rgba_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
